FILE: hw/rtl/jsm_pkg.sv
// Shared types, constants and address helpers for the Morton-order stencil block.
`timescale 1ns / 1ps

package jsm_pkg;

    localparam int GRID_BITS = 6;
    localparam int GRID_SIZE = 1 << GRID_BITS;
    localparam int COORD_W   = 6;
    localparam int CELL_W    = 32;
    localparam int ADDR_W    = 12;
    localparam int MEM_AW    = 2 * GRID_BITS;
    localparam int MEM_DEPTH = 1 << MEM_AW;
    localparam int SUM_W     = CELL_W + 2;
    localparam int NBR_CNT   = 4;
    localparam int NBR_IW    = $clog2(NBR_CNT);
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_COMPUTE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_READ,
        BS_LAST
    } t_bstate;

    typedef struct packed {
        t_op                             op;
        logic                            in_grid;
        logic                            on_edge;
        logic [ADDR_W-1:0]               addr;
        logic [NBR_CNT-1:0][ADDR_W-1:0]  nbr;
        logic [CELL_W-1:0]               value;
    } t_cmd;

    // Interleaves row bits into even and column bits into odd address positions.
    function automatic logic [ADDR_W-1:0] morton(input logic [COORD_W-1:0] r,
                                                 input logic [COORD_W-1:0] c);
        logic [ADDR_W-1:0] a;
        a = '0;
        for (int b = 0; b < GRID_BITS; b++) begin
            a[2*b]     = r[b];
            a[2*b + 1] = c[b];
        end
        return a;
    endfunction

endpackage

FILE: hw/rtl/jsm_front.sv
// Front end: takes command beats, classifies them and builds store addresses.
`timescale 1ns / 1ps

module jsm_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_op,
    input  logic [jsm_pkg::COORD_W-1:0] i_row,
    input  logic [jsm_pkg::COORD_W-1:0] i_col,
    input  logic [jsm_pkg::CELL_W-1:0]  i_cell_value,
    input  logic                        i_q_full,
    output logic                        o_push,
    output jsm_pkg::t_cmd               o_cmd
);
    import jsm_pkg::*;

    logic              r_vld;
    logic              n_vld;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic              take;
    logic [COORD_W-1:0] row_m1;
    logic [COORD_W-1:0] row_p1;
    logic [COORD_W-1:0] col_m1;
    logic [COORD_W-1:0] col_p1;

    assign busy   = r_vld && i_q_full;
    assign take   = start && !busy;
    assign o_push = r_vld && !i_q_full;
    assign o_cmd  = r_cmd;

    assign row_m1 = i_row - COORD_W'(1);
    assign row_p1 = i_row + COORD_W'(1);
    assign col_m1 = i_col - COORD_W'(1);
    assign col_p1 = i_col + COORD_W'(1);

    always_comb begin
        n_cmd.op      = t_op'(i_op);
        n_cmd.in_grid = (int'(i_row) < GRID_SIZE) && (int'(i_col) < GRID_SIZE);
        n_cmd.on_edge = (i_row == '0) || (i_col == '0) ||
                        (int'(i_row) >= GRID_SIZE - 1) || (int'(i_col) >= GRID_SIZE - 1);
        n_cmd.addr    = morton(i_row, i_col);
        n_cmd.nbr[0]  = morton(row_m1, i_col);
        n_cmd.nbr[1]  = morton(row_p1, i_col);
        n_cmd.nbr[2]  = morton(i_row, col_m1);
        n_cmd.nbr[3]  = morton(i_row, col_p1);
        n_cmd.value   = i_cell_value;
    end

    always_comb begin
        n_vld = r_vld;
        if (take) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: hw/rtl/jsm_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module jsm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsm_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output jsm_pkg::t_cmd o_head
);
    import jsm_pkg::*;

    t_cmd              r_slot [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_CW-1:0]   r_cnt;
    logic [Q_AW-1:0]   n_wp;
    logic [Q_AW-1:0]   n_rp;
    logic [Q_CW-1:0]   n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (int'(r_cnt) == Q_DEPTH);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (int'(r_wp) == Q_DEPTH - 1) ? '0 : r_wp + Q_AW'(1);
        end
        if (do_pop) begin
            n_rp = (int'(r_rp) == Q_DEPTH - 1) ? '0 : r_rp + Q_AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + Q_CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

FILE: hw/rtl/jsm_back.sv
// Back end: grid store, neighbor read sequencer and result register.
`timescale 1ns / 1ps

module jsm_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  jsm_pkg::t_cmd               i_head,
    output logic                        o_pop,
    output logic                        o_valid,
    output logic [jsm_pkg::CELL_W-1:0]  o_result_value,
    output logic [jsm_pkg::ADDR_W-1:0]  o_result_addr,
    output logic                        o_on_boundary
);
    import jsm_pkg::*;

    logic [CELL_W-1:0]              mem [MEM_DEPTH];
    t_bstate                        r_state;
    t_bstate                        n_state;
    logic [NBR_IW-1:0]              r_idx;
    logic                           r_rd_vld;
    logic [CELL_W-1:0]              r_rd_data;
    logic signed [SUM_W-1:0]        r_sum;
    logic [NBR_CNT-1:0][ADDR_W-1:0] r_nbr;
    logic [ADDR_W-1:0]              r_cell_addr;
    logic                           r_valid;
    logic [CELL_W-1:0]              r_value;
    logic [ADDR_W-1:0]              r_addr;
    logic                           r_bnd;

    logic                           mem_we;
    logic                           mem_re;
    logic                           start_seq;
    logic                           emit_edge;
    logic                           emit_sum;
    logic signed [SUM_W-1:0]        n_sum;
    logic signed [SUM_W-1:0]        quarter;

    assign n_sum   = r_sum + SUM_W'($signed(r_rd_data));
    assign quarter = n_sum >>> 2;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_q_empty && i_head.op == OP_COMPUTE && !i_head.on_edge) begin
                    n_state = BS_READ;
                end
            end
            BS_READ: begin
                if (int'(r_idx) == NBR_CNT - 1) begin
                    n_state = BS_LAST;
                end
            end
            BS_LAST: n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        start_seq = 1'b0;
        emit_edge = 1'b0;
        emit_sum  = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if (i_head.op == OP_LOAD) begin
                        mem_we = i_head.in_grid;
                    end else if (i_head.on_edge) begin
                        emit_edge = 1'b1;
                    end else begin
                        start_seq = 1'b1;
                    end
                end
            end
            BS_READ: mem_re   = 1'b1;
            BS_LAST: emit_sum = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= mem_re;
            r_valid  <= emit_edge || emit_sum;
            if (start_seq) begin
                r_idx <= '0;
            end else if (mem_re) begin
                r_idx <= r_idx + NBR_IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[i_head.addr[MEM_AW-1:0]] <= i_head.value;
        end
        if (mem_re) begin
            r_rd_data <= mem[r_nbr[r_idx][MEM_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_seq) begin
            r_nbr       <= i_head.nbr;
            r_cell_addr <= i_head.addr;
            r_sum       <= '0;
        end else if (r_rd_vld) begin
            r_sum <= n_sum;
        end
        if (emit_edge) begin
            r_value <= '0;
            r_addr  <= i_head.addr;
            r_bnd   <= 1'b1;
        end else if (emit_sum) begin
            r_value <= quarter[CELL_W-1:0];
            r_addr  <= r_cell_addr;
            r_bnd   <= 1'b0;
        end
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_value;
    assign o_result_addr  = r_addr;
    assign o_on_boundary  = r_bnd;

endmodule

FILE: hw/rtl/jacobi_stencil_morton_grid.sv
// Top level of the 5-point Jacobi stencil over a Morton-ordered grid store.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Beat contents
// command   in         start high, busy low      i_op, i_row, i_col, i_cell_value
// result    out        o_valid strobe, 1 cycle   o_result_value, o_result_addr, o_on_boundary
//
// A load beat is written into the grid store by the back end from its idle state.
// A boundary compute beat gives its result in the cycle after it leaves the queue.
// An interior compute beat makes four neighbor reads through
// the one store read port, then the sum is shifted and registered.
// Reset is synchronous; the store contents are kept and are valid only once written.
// The receiver cannot stall; busy is raised only when the command queue is full.

module jacobi_stencil_morton_grid (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_op,
    input  logic [jsm_pkg::COORD_W-1:0] i_row,
    input  logic [jsm_pkg::COORD_W-1:0] i_col,
    input  logic [jsm_pkg::CELL_W-1:0]  i_cell_value,
    output logic                        o_valid,
    output logic [jsm_pkg::CELL_W-1:0]  o_result_value,
    output logic [jsm_pkg::ADDR_W-1:0]  o_result_addr,
    output logic                        o_on_boundary
);
    import jsm_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    jsm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_cell_value (i_cell_value),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    jsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    jsm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_head         (head_cmd),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_result_addr  (o_result_addr),
        .o_on_boundary  (o_on_boundary)
    );

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the Morton-order Jacobi stencil block.
`timescale 1ns / 1ps

module tb;
    import jsm_pkg::*;

    localparam int RANDOM_ITEMS = 1200;
    localparam int IDLE_PCT     = 21;
    localparam int QUIET_FIRST  = 400;
    localparam int QUIET_LAST   = 700;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        t_op               op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [CELL_W-1:0]  value;
    } t_grid_cmd;

    typedef struct {
        logic [CELL_W-1:0] result_value;
        logic [ADDR_W-1:0] result_addr;
        logic              on_boundary;
    } t_stencil_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic i_op = 1'b0;
    logic [COORD_W-1:0] i_row = '0;
    logic [COORD_W-1:0] i_col = '0;
    logic [CELL_W-1:0] i_cell_value = '0;
    logic busy;
    logic o_valid;
    logic [CELL_W-1:0] o_result_value;
    logic [ADDR_W-1:0] o_result_addr;
    logic o_on_boundary;

    t_grid_cmd    cmd_q[$];
    t_stencil_res expected_q[$];
    logic [CELL_W-1:0] grid_mirror [MEM_DEPTH];
    bit           loaded [MEM_DEPTH];
    int           beats_in = 0;
    int           beats_done = 0;
    int           err_cnt = 0;
    int           cycle_cnt = 0;

    jacobi_stencil_morton_grid i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_cell_value   (i_cell_value),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_result_addr  (o_result_addr),
        .o_on_boundary  (o_on_boundary)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [ADDR_W-1:0] z_interleave(input logic [COORD_W-1:0] r,
                                                       input logic [COORD_W-1:0] c);
        logic [ADDR_W-1:0] a;
        a = '0;
        for (int b = GRID_BITS - 1; b >= 0; b--) begin
            a = {a[ADDR_W-3:0], c[b], r[b]};
        end
        return a;
    endfunction

    function automatic logic [CELL_W-1:0] pick_value();
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1: return CELL_W'($urandom_range(2000)) - CELL_W'(1000);
            default: return $urandom();
        endcase
    endfunction

    function automatic void add_load(input int r, input int c, input logic [CELL_W-1:0] v);
        t_grid_cmd cmd;
        cmd.op    = OP_LOAD;
        cmd.row   = COORD_W'(r);
        cmd.col   = COORD_W'(c);
        cmd.value = v;
        loaded[z_interleave(cmd.row, cmd.col)] = 1'b1;
        cmd_q.push_back(cmd);
    endfunction

    function automatic void add_compute(input int r, input int c);
        t_grid_cmd cmd;
        cmd.op    = OP_COMPUTE;
        cmd.row   = COORD_W'(r);
        cmd.col   = COORD_W'(c);
        cmd.value = $urandom();
        cmd_q.push_back(cmd);
    endfunction

    function automatic void ensure_loaded(input int r, input int c);
        if (!loaded[z_interleave(COORD_W'(r), COORD_W'(c))]) begin
            add_load(r, c, pick_value());
        end
    endfunction

    task automatic flag_mismatch(input string what, input logic [CELL_W-1:0] got,
                                 input logic [CELL_W-1:0] want);
        err_cnt++;
        $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic track_beat(input logic op_bit, input logic [COORD_W-1:0] r,
                              input logic [COORD_W-1:0] c, input logic [CELL_W-1:0] v);
        t_stencil_res res;
        logic [ADDR_W-1:0] a;
        logic signed [SUM_W-1:0] sum;
        a = z_interleave(r, c);
        if (op_bit == OP_LOAD) begin
            grid_mirror[a] = v;
        end else begin
            res.result_addr  = a;
            res.on_boundary  = (r == 0 || c == 0 || r == GRID_SIZE - 1 || c == GRID_SIZE - 1);
            res.result_value = '0;
            if (!res.on_boundary) begin
                sum = $signed(grid_mirror[z_interleave(r - 1'b1, c)])
                    + $signed(grid_mirror[z_interleave(r + 1'b1, c)])
                    + $signed(grid_mirror[z_interleave(r, c - 1'b1)])
                    + $signed(grid_mirror[z_interleave(r, c + 1'b1)]);
                res.result_value = CELL_W'(sum >>> 2);
            end
            expected_q.push_back(res);
        end
    endtask

    always @(negedge i_clk) begin : drive
        logic taken;
        bit   quiet;
        taken = (beats_in != beats_done);
        quiet = (beats_in >= QUIET_FIRST && beats_in < QUIET_LAST);
        if (taken) begin
            cmd_q.delete(0);
            beats_done++;
        end
        if (i_rst_n && (!start || taken)) begin
            if (cmd_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                i_op         <= cmd_q[0].op;
                i_row        <= cmd_q[0].row;
                i_col        <= cmd_q[0].col;
                i_cell_value <= cmd_q[0].value;
                start        <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_stencil_res want;
        cycle_cnt++;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                flag_mismatch("result with nothing pending", o_result_value, '0);
            end else begin
                want = expected_q.pop_front();
                if (o_result_value !== want.result_value) begin
                    flag_mismatch("result_value", o_result_value, want.result_value);
                end
                if (o_result_addr !== want.result_addr) begin
                    flag_mismatch("result_addr", CELL_W'(o_result_addr),
                                  CELL_W'(want.result_addr));
                end
                if (o_on_boundary !== want.on_boundary) begin
                    flag_mismatch("on_boundary", CELL_W'(o_on_boundary),
                                  CELL_W'(want.on_boundary));
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            beats_in++;
            track_beat(i_op, i_row, i_col, i_cell_value);
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : main
        int kind;
        int r;
        int c;

        // Full-scale positive neighbors, then full-scale negative ones next to the far edges.
        add_load(0, 1, 32'h7FFF_FFFF);
        add_load(2, 1, 32'h7FFF_FFFF);
        add_load(1, 0, 32'h7FFF_FFFF);
        add_load(1, 2, 32'h7FFF_FFFF);
        add_compute(1, 1);
        add_load(61, 62, 32'h8000_0000);
        add_load(63, 62, 32'h8000_0000);
        add_load(62, 61, 32'h8000_0000);
        add_load(62, 63, 32'h8000_0000);
        add_compute(62, 62);
        add_compute(0, 0);
        add_compute(0, 63);
        add_compute(63, 0);
        add_compute(63, 63);
        add_compute(0, 30);
        add_compute(45, 63);
        // A sum of minus one must round toward minus infinity.
        add_load(1, 1, '0);
        add_load(3, 1, '1);
        add_load(2, 0, '0);
        add_load(2, 2, '0);
        add_compute(2, 1);

        while (cmd_q.size() < RANDOM_ITEMS + 21) begin
            kind = $urandom_range(99);
            if (kind < 50) begin
                r = $urandom_range(GRID_SIZE - 2, 1);
                c = $urandom_range(GRID_SIZE - 2, 1);
                ensure_loaded(r - 1, c);
                ensure_loaded(r + 1, c);
                ensure_loaded(r, c - 1);
                ensure_loaded(r, c + 1);
                add_compute(r, c);
            end else if (kind < 65) begin
                r = $urandom_range(GRID_SIZE - 1);
                c = $urandom_range(GRID_SIZE - 1);
                case ($urandom_range(3))
                    0: r = 0;
                    1: r = GRID_SIZE - 1;
                    2: c = 0;
                    default: c = GRID_SIZE - 1;
                endcase
                add_compute(r, c);
            end else begin
                add_load($urandom_range(GRID_SIZE - 1), $urandom_range(GRID_SIZE - 1),
                         pick_value());
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
